// ----- hdl/rhc_pkg.sv -----
package rhc_pkg;

    // Quotient bits produced by each divider; both hue and saturation fit in 9.
    localparam int QUO_W      = 9;
    // Quotient bits resolved in each pipeline stage of the divider.
    localparam int STEP_BITS  = 3;
    localparam int DIV_STAGES = QUO_W / STEP_BITS;

    // Base hue numerators, scaled by max - min.
    localparam logic [8:0] BASE_RED_POS = 9'd0;
    localparam logic [8:0] BASE_RED_NEG = 9'd360;
    localparam logic [8:0] BASE_GREEN   = 9'd120;
    localparam logic [8:0] BASE_BLUE    = 9'd240;

    // Requested color codes.
    localparam logic [3:0] MODE_RED    = 4'd0;
    localparam logic [3:0] MODE_ORANGE = 4'd1;
    localparam logic [3:0] MODE_YELLOW = 4'd2;
    localparam logic [3:0] MODE_GREEN  = 4'd3;
    localparam logic [3:0] MODE_CYAN   = 4'd4;
    localparam logic [3:0] MODE_BLUE   = 4'd5;
    localparam logic [3:0] MODE_PURPLE = 4'd6;
    localparam logic [3:0] MODE_WHITE  = 4'd7;
    localparam logic [3:0] MODE_BLACK  = 4'd8;
    localparam logic [3:0] MODE_GRAY   = 4'd9;

    // Which component is the maximum, and for red the sign of green - blue.
    typedef enum logic [1:0] {
        SEC_RED_POS,
        SEC_RED_NEG,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Partial state of one restoring divider.
    typedef struct packed {
        logic [7:0]       divisor;
        logic [7:0]       rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } t_div;

    // Item fields that ride along with the dividers.
    typedef struct packed {
        logic [6:0] brightness;
        logic       d_zero;
        logic       mx_zero;
        logic [3:0] mode;
    } t_side;

endpackage

// ----- hdl/rgb_to_hsb_color_classifier_core.sv -----
// Converts one 8-bit RGB pixel to whole-degree hue, saturation and brightness
// percent, and flags whether it lies in the range of the requested color. A new
// item is taken on every cycle that start is high (busy is always low), and its
// result appears with o_strobe high, in order, once through the pipeline: one
// stage finds max and min, one forms the hue and saturation dividends, three
// stages of a restoring divider resolve three quotient bits each, and one stage
// classifies. Results cannot be held off; the receiver must take each one in
// the cycle it is shown.
module rgb_to_hsb_color_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [3:0] i_mode,
    output logic       busy,
    output logic       o_strobe,
    output logic [8:0] o_hue,
    output logic [6:0] o_saturation,
    output logic [6:0] o_brightness,
    output logic       o_is_match
);

    // Stage one registers.
    logic              r1_valid;
    rhc_pkg::t_sector  r1_sector, n1_sector;
    logic [7:0]        r1_d, n1_d;
    logic [7:0]        r1_mx, n1_mx;
    logic signed [8:0] r1_sdiff, n1_sdiff;
    logic [3:0]        r1_mode;
    logic [7:0]        mn;

    // Stage two registers.
    logic              r2_valid;
    rhc_pkg::t_div     r2_hue, n2_hue;
    rhc_pkg::t_div     r2_sat, n2_sat;
    rhc_pkg::t_side    r2_side, n2_side;
    logic [8:0]        base;
    logic [16:0]       base_d;
    logic signed [18:0] diff_ext;
    logic signed [18:0] num_s;
    logic [16:0]       sat_num;
    logic [14:0]       mx100;
    logic [15:0]       v_sum;

    // Divider chain.
    logic              dv_valid [rhc_pkg::DIV_STAGES+1];
    rhc_pkg::t_div     dv_hue   [rhc_pkg::DIV_STAGES+1];
    rhc_pkg::t_div     dv_sat   [rhc_pkg::DIV_STAGES+1];
    rhc_pkg::t_side    dv_side  [rhc_pkg::DIV_STAGES+1];

    // Output registers.
    logic              r_strobe;
    logic [8:0]        r_hue, n_hue;
    logic [6:0]        r_sat, n_sat;
    logic [6:0]        r_bright;
    logic              r_match, n_match;
    rhc_pkg::t_side    last_side;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Max, min, spread and the sector that picks the hue formula.
    always_comb begin
        n1_mx = i_red;
        if (i_green > n1_mx) n1_mx = i_green;
        if (i_blue > n1_mx) n1_mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        n1_d = n1_mx - mn;
        priority if (n1_mx == i_red && i_green >= i_blue) begin
            n1_sector = rhc_pkg::SEC_RED_POS;
            n1_sdiff  = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n1_mx == i_red) begin
            n1_sector = rhc_pkg::SEC_RED_NEG;
            n1_sdiff  = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n1_mx == i_green) begin
            n1_sector = rhc_pkg::SEC_GREEN;
            n1_sdiff  = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n1_sector = rhc_pkg::SEC_BLUE;
            n1_sdiff  = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sector <= n1_sector;
        r1_d      <= n1_d;
        r1_mx     <= n1_mx;
        r1_sdiff  <= n1_sdiff;
        r1_mode   <= i_mode;
    end

    // Dividends for hue and saturation, and brightness by reciprocal of 255.
    always_comb begin
        unique case (r1_sector)
            rhc_pkg::SEC_RED_POS: base = rhc_pkg::BASE_RED_POS;
            rhc_pkg::SEC_RED_NEG: base = rhc_pkg::BASE_RED_NEG;
            rhc_pkg::SEC_GREEN:   base = rhc_pkg::BASE_GREEN;
            rhc_pkg::SEC_BLUE:    base = rhc_pkg::BASE_BLUE;
            default:              base = rhc_pkg::BASE_RED_POS;
        endcase
        base_d   = 17'(base) * 17'(r1_d);
        diff_ext = 19'(r1_sdiff);
        num_s    = $signed({2'b00, base_d}) + diff_ext * 19'sd60;
        sat_num  = 17'(r1_d) * 17'd100;
        mx100    = 15'(r1_mx) * 15'd100;
        v_sum    = 16'(mx100) + 16'(mx100[14:8]) + 16'd1;

        n2_hue.divisor = r1_d;
        n2_hue.rem     = num_s[16:9];
        n2_hue.low     = num_s[8:0];
        n2_hue.quo     = '0;
        n2_sat.divisor = r1_mx;
        n2_sat.rem     = sat_num[16:9];
        n2_sat.low     = sat_num[8:0];
        n2_sat.quo     = '0;

        n2_side.brightness = v_sum[14:8];
        n2_side.d_zero     = (r1_d == 8'd0);
        n2_side.mx_zero    = (r1_mx == 8'd0);
        n2_side.mode       = r1_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hue  <= n2_hue;
        r2_sat  <= n2_sat;
        r2_side <= n2_side;
    end

    // Divider stages, three quotient bits each.
    assign dv_valid[0] = r2_valid;
    assign dv_hue[0]   = r2_hue;
    assign dv_sat[0]   = r2_sat;
    assign dv_side[0]  = r2_side;

    for (genvar i = 0; i < rhc_pkg::DIV_STAGES; i++) begin : g_div
        rhc_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[i]),
            .i_hue   (dv_hue[i]),
            .i_sat   (dv_sat[i]),
            .i_side  (dv_side[i]),
            .o_valid (dv_valid[i+1]),
            .o_hue   (dv_hue[i+1]),
            .o_sat   (dv_sat[i+1]),
            .o_side  (dv_side[i+1])
        );
    end

    // Pixels with no spread (gray, white, black) get hue zero and black pixels get saturation zero, not the quotient.
    assign last_side = dv_side[rhc_pkg::DIV_STAGES];
    assign n_hue = last_side.d_zero ? 9'd0 : dv_hue[rhc_pkg::DIV_STAGES].quo;
    assign n_sat = last_side.mx_zero ? 7'd0 : dv_sat[rhc_pkg::DIV_STAGES].quo[6:0];

    rhc_classify u_classify (
        .i_hue    (n_hue),
        .i_sat    (n_sat),
        .i_bright (last_side.brightness),
        .i_mode   (last_side.mode),
        .o_match  (n_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_valid[rhc_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue    <= n_hue;
        r_sat    <= n_sat;
        r_bright <= last_side.brightness;
        r_match  <= n_match;
    end

    assign o_strobe     = r_strobe;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;
    assign o_is_match   = r_match;

`ifndef SYNTHESIS
    // Every accepted item comes out with o_strobe high.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted item did not produce a result on time");

    // The divider must never leave the hue range.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue <= 9'd359))
        else $error("hue out of range");

    // Percentages stay within bounds.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_saturation <= 7'd100 && o_brightness <= 7'd100))
        else $error("saturation or brightness out of range");
`endif

endmodule

// ----- hdl/rhc_div_stage.sv -----
module rhc_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rhc_pkg::t_div i_hue,
    input  rhc_pkg::t_div i_sat,
    input  rhc_pkg::t_side i_side,
    output logic          o_valid,
    output rhc_pkg::t_div o_hue,
    output rhc_pkg::t_div o_sat,
    output rhc_pkg::t_side o_side
);

    logic           r_valid;
    rhc_pkg::t_div  r_hue;
    rhc_pkg::t_div  r_sat;
    rhc_pkg::t_side r_side;
    rhc_pkg::t_div  n_hue;
    rhc_pkg::t_div  n_sat;

    // STEP_BITS restoring steps: shift in one dividend bit, subtract if it fits.
    function automatic rhc_pkg::t_div div_steps(input rhc_pkg::t_div d_in);
        rhc_pkg::t_div d;
        logic [8:0]    rem9;
        d = d_in;
        for (int k = 0; k < rhc_pkg::STEP_BITS; k++) begin
            rem9  = {d.rem, d.low[rhc_pkg::QUO_W-1]};
            d.low = {d.low[rhc_pkg::QUO_W-2:0], 1'b0};
            if (rem9 >= {1'b0, d.divisor}) begin
                rem9  = rem9 - {1'b0, d.divisor};
                d.quo = {d.quo[rhc_pkg::QUO_W-2:0], 1'b1};
            end else begin
                d.quo = {d.quo[rhc_pkg::QUO_W-2:0], 1'b0};
            end
            d.rem = rem9[7:0];
        end
        return d;
    endfunction

    always_comb begin
        n_hue = div_steps(i_hue);
        n_sat = div_steps(i_sat);
    end

    // Valid bit is control state; the payload follows without reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue  <= n_hue;
        r_sat  <= n_sat;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_side  = r_side;

endmodule

// ----- hdl/rhc_classify.sv -----
module rhc_classify (
    input  logic [8:0] i_hue,
    input  logic [6:0] i_sat,
    input  logic [6:0] i_bright,
    input  logic [3:0] i_mode,
    output logic       o_match
);

    logic gate;
    logic chroma;

    // Chromatic ranges apply only to vivid pixels.
    assign gate = (i_mode != rhc_pkg::MODE_BLACK) && (i_sat > 7'd15) && (i_bright > 7'd25);

    always_comb begin
        unique case (i_mode)
            rhc_pkg::MODE_RED:    chroma = (i_hue > 9'd0 && i_hue <= 9'd11) ||
                                           (i_hue >= 9'd340 && i_hue <= 9'd360);
            rhc_pkg::MODE_ORANGE: chroma = (i_hue >= 9'd18) && (i_hue <= 9'd39);
            rhc_pkg::MODE_YELLOW: chroma = (i_hue >= 9'd41) && (i_hue <= 9'd62);
            rhc_pkg::MODE_GREEN:  chroma = (i_hue >= 9'd67) && (i_hue <= 9'd174);
            rhc_pkg::MODE_CYAN:   chroma = (i_hue >= 9'd175) && (i_hue <= 9'd193);
            rhc_pkg::MODE_BLUE:   chroma = (i_hue > 9'd194) && (i_hue <= 9'd255);
            rhc_pkg::MODE_PURPLE: chroma = (i_hue >= 9'd256) && (i_hue <= 9'd337);
            default:              chroma = 1'b0;
        endcase
    end

    // Achromatic colors are tested only when the gate is closed.
    always_comb begin
        if (gate) begin
            o_match = chroma;
        end else if (i_mode == rhc_pkg::MODE_WHITE) begin
            o_match = (i_hue < 9'd20) && (i_sat <= 7'd7) && (i_bright >= 7'd80);
        end else if (i_mode == rhc_pkg::MODE_BLACK) begin
            o_match = (i_bright <= 7'd25);
        end else if (i_mode == rhc_pkg::MODE_GRAY) begin
            o_match = (i_hue > 9'd80) && (i_sat <= 7'd15) && (i_bright >= 7'd30) &&
                      (i_sat < i_bright);
        end else begin
            o_match = 1'b0;
        end
    end

endmodule
